/* src/lbs_pkg.sv */
// Shared types and constants for the linear blend skinning position unit.
// No dependencies; lbs_blend, lbs_xform, the top and the tests import it.
`default_nettype none
package lbs_pkg;

  localparam int ELEMS = 12;
  localparam int BONES = 4;
  localparam int DATA_W = 32;
  localparam int WT_W = 8;
  localparam int SUM_W = 42;
  localparam int MAG_W = 42;
  localparam int ACC_W = 43;
  localparam int QUO_W = 35;
  localparam int PROD_W = 64;
  localparam int DOT_W = 66;
  localparam int RES_W = 67;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_SKIN = 1'b1;

  typedef struct packed {
    logic valid;
    logic pass;
    logic [2:0][DATA_W-1:0] pos;
  } meta_t;

endpackage
`default_nettype wire

/* src/lbs_item_if.sv */
// Input channel of the skinning unit: valid, ready and the item payload.
// Depends on nothing.
`default_nettype none
interface lbs_item_if;
  logic valid;
  logic ready;
  logic kind;
  logic [7:0] load_bone;
  logic [3:0] load_element;
  logic signed [31:0] load_value;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic [7:0] bone_a;
  logic [7:0] bone_b;
  logic [7:0] bone_c;
  logic [7:0] bone_d;
  logic [31:0] blend_weights;

  modport source(output valid, kind, load_bone, load_element, load_value, pos_x, pos_y,
                 pos_z, bone_a, bone_b, bone_c, bone_d, blend_weights, input ready);
  modport sink(input valid, kind, load_bone, load_element, load_value, pos_x, pos_y,
               pos_z, bone_a, bone_b, bone_c, bone_d, blend_weights, output ready);
endinterface
`default_nettype wire

/* src/lbs_result_if.sv */
// Output channel of the skinning unit: valid, ready and the skinned position.
// Depends on nothing.
`default_nettype none
interface lbs_result_if;
  logic valid;
  logic ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;

  modport source(output valid, out_x, out_y, out_z, input ready);
  modport sink(input valid, out_x, out_y, out_z, output ready);
endinterface
`default_nettype wire

/* src/lbs_ram.sv */
// Generic single write port, single registered read port memory.
// Depends on nothing.
`default_nettype none
module lbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* src/lbs_blend.sv */
// Weighted blend of four bone matrices with rounding division by 255.
// Depends on lbs_pkg; four register stages.
`default_nettype none
module lbs_blend import lbs_pkg::*; (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               en,
  input  wire meta_t                              meta_in,
  input  wire logic [BONES-1:0][WT_W-1:0]         weights,
  input  wire logic [BONES-1:0]                   bone_ok,
  input  wire logic [BONES-1:0][ELEMS-1:0][DATA_W-1:0] rd_data,
  output meta_t                                   meta_out,
  output logic [ELEMS-1:0][DATA_W-1:0]            blend
);

  meta_t meta2, meta3, meta4;
  logic signed [SUM_W-1:0] sum2 [ELEMS];
  logic [MAG_W-1:0] mag3 [ELEMS];
  logic [MAG_W-1:0] mag4 [ELEMS];
  logic [QUO_W-1:0] quo4 [ELEMS];
  logic [ELEMS-1:0] neg3, neg4;

  logic signed [SUM_W-1:0] sum_next [ELEMS];
  logic [MAG_W-1:0] mag_next [ELEMS];
  logic [QUO_W-1:0] quo_next [ELEMS];
  logic [ELEMS-1:0][DATA_W-1:0] blend_next;

  always_comb begin
    logic signed [SUM_W-1:0] acc;
    logic signed [DATA_W-1:0] d;
    logic signed [WT_W:0] w;
    for (int e = 0; e < ELEMS; e++) begin
      acc = '0;
      for (int k = 0; k < BONES; k++) begin
        d = bone_ok[k] ? $signed(rd_data[k][e]) : '0;
        w = $signed({1'b0, weights[k]});
        acc = acc + d * w;
      end
      sum_next[e] = acc;
    end
  end

  always_comb begin
    logic [MAG_W-1:0] m;
    for (int e = 0; e < ELEMS; e++) begin
      m = sum2[e][SUM_W-1] ? MAG_W'(-sum2[e]) : MAG_W'(sum2[e]);
      mag_next[e] = m + MAG_W'(127);
    end
  end

  always_comb begin
    logic [ACC_W-1:0] t;
    for (int e = 0; e < ELEMS; e++) begin
      t = ACC_W'(mag3[e]) + ACC_W'(mag3[e] >> 8) + ACC_W'(mag3[e] >> 16)
        + ACC_W'(mag3[e] >> 24) + ACC_W'(mag3[e] >> 32) + ACC_W'(mag3[e] >> 40);
      quo_next[e] = t[ACC_W-1:8];
    end
  end

  always_comb begin
    logic [ACC_W-1:0] r;
    logic [QUO_W-1:0] q;
    for (int e = 0; e < ELEMS; e++) begin
      r = ACC_W'(mag4[e]) - (ACC_W'(quo4[e]) << 8) + ACC_W'(quo4[e]);
      q = quo4[e] + ((r >= ACC_W'(255)) ? QUO_W'(1) : QUO_W'(0));
      if (!neg4[e]) begin
        blend_next[e] = (q > QUO_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : q[DATA_W-1:0];
      end else begin
        blend_next[e] = (q > QUO_W'(32'h8000_0000)) ? 32'h8000_0000 : -q[DATA_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      meta2.valid <= 1'b0;
      meta3.valid <= 1'b0;
      meta4.valid <= 1'b0;
      meta_out.valid <= 1'b0;
    end else if (en) begin
      meta2 <= meta_in;
      meta3 <= meta2;
      meta4 <= meta3;
      meta_out <= meta4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int e = 0; e < ELEMS; e++) begin
        sum2[e] <= sum_next[e];
        mag3[e] <= mag_next[e];
        neg3[e] <= sum2[e][SUM_W-1];
        mag4[e] <= mag3[e];
        neg4[e] <= neg3[e];
        quo4[e] <= quo_next[e];
      end
      blend <= blend_next;
    end
  end

endmodule
`default_nettype wire

/* src/lbs_xform.sv */
// Applies the blended 3x4 matrix to the position with rounding and saturation.
// Depends on lbs_pkg; three register stages, the last is the output register.
`default_nettype none
module lbs_xform import lbs_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         en,
  input  wire meta_t                        meta_in,
  input  wire logic [ELEMS-1:0][DATA_W-1:0] blend,
  output logic                              out_valid,
  output logic [2:0][DATA_W-1:0]            out_pos
);

  meta_t meta6, meta7;
  logic signed [PROD_W-1:0] prod6 [3][3];
  logic signed [DATA_W-1:0] ofs6 [3];
  logic signed [DATA_W-1:0] ofs7 [3];
  logic signed [DOT_W-1:0] dot7 [3];
  logic signed [PROD_W-1:0] prod_next [3][3];
  logic signed [DOT_W-1:0] dot_next [3];
  logic [2:0][DATA_W-1:0] pos_next;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_next[r][c] = $signed(blend[r*4+c]) * $signed(meta_in.pos[c]);
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      dot_next[r] = DOT_W'(prod6[r][0]) + DOT_W'(prod6[r][1]) + DOT_W'(prod6[r][2])
                  + (DOT_W'(1) <<< (FRAC_BITS - 1));
    end
  end

  always_comb begin
    logic signed [RES_W-1:0] res;
    for (int r = 0; r < 3; r++) begin
      res = RES_W'(dot7[r] >>> FRAC_BITS) + RES_W'(ofs7[r]);
      if (meta7.pass) begin
        pos_next[r] = meta7.pos[r];
      end else if (res > RES_W'(64'sd2147483647)) begin
        pos_next[r] = 32'h7FFF_FFFF;
      end else if (res < RES_W'(-64'sd2147483648)) begin
        pos_next[r] = 32'h8000_0000;
      end else begin
        pos_next[r] = res[DATA_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      meta6.valid <= 1'b0;
      meta7.valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      meta6 <= meta_in;
      meta7 <= meta6;
      out_valid <= meta7.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod6[r][c] <= prod_next[r][c];
        end
        ofs6[r] <= $signed(blend[r*4+3]);
        ofs7[r] <= ofs6[r];
        dot7[r] <= dot_next[r];
      end
      out_pos <= pos_next;
    end
  end

endmodule
`default_nettype wire

/* src/linear_blend_skin_position_unit.sv */
// Top level of the linear blend skinning position unit.
// Depends on lbs_pkg, lbs_item_if, lbs_result_if, lbs_ram, lbs_blend and lbs_xform.
//
// Items arrive on the item channel. A load item writes one element of a bone
// matrix into the bone table in the cycle of its transfer and gives no result.
// A load whose element is twelve or more writes nothing. A skin item gives one
// result on the result channel and may follow a load of the same bone at once.
// The unit takes one item per cycle while the receiver does not stall. The bone
// table is held as twelve element memories, each copied four times so that all
// four bones are read in one cycle. Results leave in order. When the receiver
// stalls, the whole pipeline holds, and ready stays low until the output register
// can move. Reset clears the pipeline and skin_enable; the bone table holds
// nothing defined until loaded. The user writes skin_enable through cfg_we and
// cfg_wdata only while no skin item is in flight; the block does not enforce it.
`default_nettype none
module linear_blend_skin_position_unit import lbs_pkg::*; #(
  parameter int BONE_SLOTS = 256,
  parameter int FRAC_BITS = 16
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  cfg_we,
  input  wire logic  cfg_wdata,
  lbs_item_if.sink   item,
  lbs_result_if.source result
);

  localparam int AW = $clog2(BONE_SLOTS);

  logic skin_enable;
  logic en;
  logic accept;
  logic load_ok;
  logic [BONES-1:0][7:0] bones;
  logic [ELEMS-1:0] wr_en;
  logic [AW-1:0] wr_addr;
  logic [BONES-1:0][ELEMS-1:0][DATA_W-1:0] rd_data;
  meta_t meta1, meta5;
  logic [BONES-1:0][WT_W-1:0] weights1;
  logic [BONES-1:0] bone_ok1;
  logic [ELEMS-1:0][DATA_W-1:0] blend5;
  logic [2:0][DATA_W-1:0] out_pos;
  logic out_valid;

  assign en = !out_valid || result.ready;
  assign item.ready = en;
  assign accept = item.valid && en;
  assign bones = {item.bone_d, item.bone_c, item.bone_b, item.bone_a};
  assign load_ok = (32'(item.load_bone) < BONE_SLOTS);
  assign wr_addr = AW'(item.load_bone);

  always_comb begin
    for (int e = 0; e < ELEMS; e++) begin
      wr_en[e] = accept && (item.kind == KIND_LOAD) && load_ok
                 && (item.load_element == 4'(e));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      skin_enable <= 1'b0;
    end else if (cfg_we) begin
      skin_enable <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      meta1.valid <= 1'b0;
    end else if (en) begin
      meta1.valid <= accept && (item.kind == KIND_SKIN);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      meta1.pass <= !skin_enable;
      meta1.pos <= {item.pos_z, item.pos_y, item.pos_x};
      weights1 <= item.blend_weights;
      for (int k = 0; k < BONES; k++) begin
        bone_ok1[k] <= (32'(bones[k]) < BONE_SLOTS);
      end
    end
  end

  for (genvar e = 0; e < ELEMS; e++) begin : g_elem
    for (genvar k = 0; k < BONES; k++) begin : g_copy
      lbs_ram #(
        .WIDTH(DATA_W),
        .DEPTH(BONE_SLOTS)
      ) u_ram (
        .clk(clk),
        .we(wr_en[e]),
        .waddr(wr_addr),
        .wdata(item.load_value),
        .re(en),
        .raddr(AW'(bones[k])),
        .rdata(rd_data[k][e])
      );
    end
  end

  lbs_blend u_blend (
    .clk(clk),
    .rst(rst),
    .en(en),
    .meta_in(meta1),
    .weights(weights1),
    .bone_ok(bone_ok1),
    .rd_data(rd_data),
    .meta_out(meta5),
    .blend(blend5)
  );

  lbs_xform #(
    .FRAC_BITS(FRAC_BITS)
  ) u_xform (
    .clk(clk),
    .rst(rst),
    .en(en),
    .meta_in(meta5),
    .blend(blend5),
    .out_valid(out_valid),
    .out_pos(out_pos)
  );

  assign result.valid = out_valid;
  assign result.out_x = out_pos[0];
  assign result.out_y = out_pos[1];
  assign result.out_z = out_pos[2];

endmodule
`default_nettype wire

/* test/lbs_skin_checker.sv */
`timescale 1ns / 100ps
// Checker for the skinning unit: watches the item, result and register ports,
// predicts each skinned position and compares it with what leaves the unit.
// Depends on lbs_pkg, lbs_item_if and lbs_result_if.
module lbs_skin_checker import lbs_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    cfg_we,
  input  logic    cfg_wdata,
  lbs_item_if     item,
  lbs_result_if   result,
  output int      fail_count,
  output int      pending
);

  logic signed [31:0] bone_matrix [256][12];
  logic skinning_on;
  logic [2:0][31:0] expected_positions [$];

  function automatic logic signed [31:0] clamp32(input logic signed [67:0] v);
    if (v > 68'sd2147483647) return 32'sh7fffffff;
    if (v < -68'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic [2:0][31:0] skinned_position(
      input logic signed [31:0] px, py, pz,
      input logic [7:0] ba, bb, bc, bd,
      input logic [31:0] wts);
    longint pos [3];
    longint blended [12];
    logic [7:0] bones [4];
    longint s, q;
    logic signed [67:0] acc;
    logic [2:0][31:0] res;
    pos[0] = px;
    pos[1] = py;
    pos[2] = pz;
    if (!skinning_on) begin
      res[0] = px;
      res[1] = py;
      res[2] = pz;
      return res;
    end
    bones[0] = ba;
    bones[1] = bb;
    bones[2] = bc;
    bones[3] = bd;
    for (int e = 0; e < 12; e++) begin
      s = 0;
      for (int k = 0; k < 4; k++)
        s += longint'(bone_matrix[bones[k]][e]) * longint'({56'd0, wts[8*k +: 8]});
      if (s >= 0) q = (s + 127) / 255;
      else q = -((-s + 127) / 255);
      blended[e] = longint'(clamp32(68'(q)));
    end
    for (int r = 0; r < 3; r++) begin
      acc = 0;
      for (int c = 0; c < 3; c++)
        acc += 68'(blended[r*4+c]) * 68'(pos[c]);
      acc = ((acc + 68'sd32768) >>> 16) + 68'(blended[r*4+3]);
      res[r] = clamp32(acc);
    end
    return res;
  endfunction

  always @(posedge clk) begin
    logic [2:0][31:0] want;
    if (rst) begin
      skinning_on = 1'b0;
      expected_positions.delete();
    end else begin
      if (cfg_we) skinning_on = cfg_wdata;
      if (result.valid && result.ready) begin
        if (expected_positions.size() == 0) begin
          $error("unexpected result transfer x=%h y=%h z=%h",
                 result.out_x, result.out_y, result.out_z);
          fail_count++;
        end else begin
          want = expected_positions.pop_front();
          if (result.out_x !== want[0]) begin
            $error("out_x expected %h actual %h", want[0], result.out_x);
            fail_count++;
          end
          if (result.out_y !== want[1]) begin
            $error("out_y expected %h actual %h", want[1], result.out_y);
            fail_count++;
          end
          if (result.out_z !== want[2]) begin
            $error("out_z expected %h actual %h", want[2], result.out_z);
            fail_count++;
          end
        end
      end
      if (item.valid && item.ready) begin
        if (item.kind == KIND_SKIN)
          expected_positions.push_back(skinned_position(item.pos_x, item.pos_y, item.pos_z,
              item.bone_a, item.bone_b, item.bone_c, item.bone_d, item.blend_weights));
        else if (item.load_element < 12)
          bone_matrix[item.load_bone][item.load_element] = item.load_value;
      end
    end
    pending = expected_positions.size();
  end

  initial begin
    fail_count = 0;
    pending = 0;
  end

endmodule

/* test/tb_linear_blend_skin_position_unit.sv */
`timescale 1ns / 100ps
// Testbench top for the skinning unit: clock, reset, register writes and
// item traffic with random gaps and stalls. Depends on lbs_pkg, both channel
// interfaces, lbs_skin_checker and the unit itself.
module tb_linear_blend_skin_position_unit import lbs_pkg::*;;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_wdata;
  logic steady;
  int fail_count;
  int pending;
  logic [11:0] elems_written [256];
  logic [7:0] ready_bones [$];

  lbs_item_if item ();
  lbs_result_if result ();

  linear_blend_skin_position_unit u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .item(item), .result(result)
  );

  lbs_skin_checker u_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .item(item), .result(result), .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("linear_blend_skin_position_unit regression: fail");
    $finish;
  end

  always @(posedge clk) begin
    if (rst) result.ready <= 1'b0;
    else result.ready <= steady || ($urandom_range(99) >= 11);
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(131072) - 65536;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_weights();
    logic [7:0] a;
    case ($urandom_range(5))
      0: return 32'h0;
      1: return 32'hffffffff;
      2: begin
        a = 8'($urandom_range(255));
        return {8'd0, 8'd0, 8'(255 - a), a};
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic transfer_item(input logic kind, input logic [7:0] lb, input logic [3:0] le,
      input logic [31:0] lv, input logic [31:0] px, py, pz,
      input logic [7:0] ba, bb, bc, bd, input logic [31:0] wts);
    if (!steady && $urandom_range(99) < 11) begin
      item.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    item.valid <= 1'b1;
    item.kind <= kind;
    item.load_bone <= lb;
    item.load_element <= le;
    item.load_value <= lv;
    item.pos_x <= px;
    item.pos_y <= py;
    item.pos_z <= pz;
    item.bone_a <= ba;
    item.bone_b <= bb;
    item.bone_c <= bc;
    item.bone_d <= bd;
    item.blend_weights <= wts;
    do @(negedge clk); while (!item.ready);
    @(posedge clk);
    if (kind == KIND_LOAD && le < 12) begin
      elems_written[lb][le] = 1'b1;
      if (elems_written[lb] == 12'hfff && !(lb inside {ready_bones}))
        ready_bones.push_back(lb);
    end
  endtask

  task automatic load_element(input logic [7:0] b, input logic [3:0] e, input logic [31:0] v);
    transfer_item(KIND_LOAD, b, e, v, $urandom, $urandom, $urandom,
                  8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), $urandom);
  endtask

  task automatic skin_vertex(input logic [31:0] px, py, pz,
      input logic [7:0] ba, bb, bc, bd, input logic [31:0] wts);
    transfer_item(KIND_SKIN, 8'($urandom), 4'($urandom), $urandom, px, py, pz,
                  ba, bb, bc, bd, wts);
  endtask

  function automatic logic [7:0] loaded_bone();
    return ready_bones[$urandom_range(ready_bones.size() - 1)];
  endfunction

  task automatic skin_loaded();
    skin_vertex(rand_word(), rand_word(), rand_word(),
                loaded_bone(), loaded_bone(), loaded_bone(), loaded_bone(), rand_weights());
  endtask

  task automatic drain();
    item.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_enable(input logic v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_items(input int count, input logic enabled);
    for (int i = 0; i < count; i++) begin
      steady = (i >= count / 3) && (i < count / 3 + 60);
      case ($urandom_range(19))
        0, 1, 2, 3, 4, 5:
          if (enabled) load_element(loaded_bone(), 4'($urandom_range(11)), rand_word());
          else load_element(8'($urandom), 4'($urandom_range(11)), rand_word());
        6: load_element(8'($urandom), 4'($urandom_range(12, 15)), rand_word());
        7: begin
          logic [7:0] b = 8'($urandom);
          for (int e = 0; e < 12; e++) load_element(b, 4'(e), rand_word());
        end
        default:
          if (enabled) skin_loaded();
          else skin_vertex($urandom, $urandom, $urandom, 8'($urandom), 8'($urandom),
                           8'($urandom), 8'($urandom), $urandom);
      endcase
    end
    steady = 1'b0;
  endtask

  initial begin
    logic [31:0] m;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    steady = 1'b0;
    item.valid = 1'b0;
    item.kind = KIND_LOAD;
    item.load_bone = '0;
    item.load_element = '0;
    item.load_value = '0;
    item.pos_x = '0;
    item.pos_y = '0;
    item.pos_z = '0;
    item.bone_a = '0;
    item.bone_b = '0;
    item.bone_c = '0;
    item.bone_d = '0;
    item.blend_weights = '0;
    result.ready = 1'b0;
    for (int b = 0; b < 256; b++) elems_written[b] = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_enable(1'b0);

    skin_vertex(32'h7fffffff, 32'h80000000, 32'h0, 8'd255, 8'd0, 8'd17, 8'd200, 32'hffffffff);
    for (int e = 0; e < 12; e++) load_element(8'd0, 4'(e), 32'h7fffffff);
    for (int e = 0; e < 12; e++) load_element(8'd255, 4'(e), 32'h80000000);
    load_element(8'd3, 4'd15, 32'h12345678);
    write_enable(1'b1);
    skin_vertex(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 8'd0, 8'd0, 8'd0, 8'd0, 32'hffffffff);
    skin_vertex(32'h80000000, 32'h7fffffff, 32'h80000000, 8'd255, 8'd255, 8'd0, 8'd255,
                32'hffffffff);
    skin_vertex(32'h00010000, 32'hffff0000, 32'h0, 8'd0, 8'd255, 8'd0, 8'd255, 32'h0);
    skin_vertex(32'h00010000, 32'h00020000, 32'h00030000, 8'd0, 8'd255, 8'd0, 8'd0,
                32'h00000180);
    for (int e = 0; e < 12; e++) begin
      m = (e % 5 == 0) ? 32'h00010000 : 32'h0;
      load_element(8'd1, 4'(e), m);
    end
    skin_vertex(32'h7fffffff, 32'h80000000, 32'h00018000, 8'd1, 8'd1, 8'd1, 8'd1,
                32'h000000ff);

    random_items(95, 1'b0);
    write_enable(1'b1);
    random_items(190, 1'b1);
    write_enable(1'b0);
    random_items(40, 1'b0);
    write_enable(1'b1);
    random_items(75, 1'b1);
    drain();

    if (fail_count == 0)
      $display("linear_blend_skin_position_unit regression: pass");
    else
      $display("linear_blend_skin_position_unit regression: fail");
    $finish;
  end

endmodule

/* files.f */
src/lbs_pkg.sv
src/lbs_item_if.sv
src/lbs_result_if.sv
src/lbs_ram.sv
src/lbs_blend.sv
src/lbs_xform.sv
src/linear_blend_skin_position_unit.sv
test/lbs_skin_checker.sv
test/tb_linear_blend_skin_position_unit.sv
